// ===== rtl/p1305_pkg.sv =====
// Poly1305 authenticator package: limb widths, key clamp masks, sequencer
// states, register indexes and the block padding function.
// No dependencies; imported by poly1305_mac_top, the tag checker and the testbench.
package p1305_pkg;

    // Radix 2^26 limb arithmetic
    localparam int NLIMB   = 5;
    localparam int LIMB_W  = 26;
    localparam int ACC_W   = 27;              // limb 1 may hold one bit beyond 26
    localparam int HS_W    = 28;              // accumulator limb plus message limb
    localparam int COEF_W  = 29;              // r limb times five
    localparam int PROD_W  = HS_W + COEF_W;
    localparam int DACC_W  = 61;              // column sum of five products plus carry
    localparam int CARRY_W = DACC_W - LIMB_W;
    localparam int FOLD_W  = 39;              // limb 0 plus five times the top carry

    // Key clamp masks for r
    localparam logic [63:0] CLAMP_LOW  = 64'h0ffffffc0fffffff;
    localparam logic [63:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;

    // Block size in bytes
    localparam logic [4:0] FULL_BYTES = 5'd16;

    typedef logic [ACC_W-1:0]  acc_limb_t;
    typedef logic [LIMB_W-1:0] r_limb_t;
    typedef logic [HS_W-1:0]   hs_limb_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_FOLD,
        ST_FIN_CARRY,
        ST_FIN_SUB,
        ST_FIN_TAG
    } p1305_state_t;

    typedef enum logic [1:0] {
        REG_R_LOW,
        REG_R_HIGH,
        REG_S_LOW,
        REG_S_HIGH
    } p1305_reg_t;

    // Sequencer decode
    typedef struct packed {
        logic in_stall;
        logic mul_issue;
        logic fold;
        logic fin_carry;
        logic fin_sub;
        logic fin_tag;
    } p1305_ctrl_t;

    // Keep the valid bytes, put 0x01 after them, add 2^128 for a full block.
    // Counts above sixteen count as a full block.
    function automatic logic [129:0] pad_block(input logic [63:0] lo,
                                               input logic [63:0] hi,
                                               input logic [4:0]  count);
        logic [127:0] blk;
        logic [129:0] res;
        logic [4:0]   n;
        blk = {hi, lo};
        n   = (count > FULL_BYTES) ? FULL_BYTES : count;
        res = '0;
        for (int b = 0; b < 16; b++)
        begin
            if (n > 5'(b))
            begin
                res[8*b +: 8] = blk[8*b +: 8];
            end
            else if (n == 5'(b))
            begin
                res[8*b] = 1'b1;
            end
        end
        res[128] = (n == FULL_BYTES);
        return res;
    endfunction

endpackage

// ===== rtl/poly1305_mac_top.sv =====
// Poly1305 one-time authenticator: block absorption on one shared limb
// multiplier under a small sequencer, then final reduction and s addition.
// Depends on p1305_pkg.
//
// Usage:
//   Configuration: write r_low (0), r_high (1), s_low (2), s_high (3) on the
//   cfg channel (cfg_ready is always high) while no message is in progress.
//   Input: each transfer carries one 16-byte block as block_low/block_high
//   with byte_count (16 full, 1-15 padded, 0 nothing) and last.
//   Output: one tag transfer per message, after the block marked last.
// Sequence:
//   A non-empty block is followed by 25 limb products through the single
//   28x29 multiplier, a drain step and a carry fold before the next input
//   transfer can be taken; in_stall is high for all of that.
//   With last set the tag follows the fold through carry, subtract p and add s
//   steps; an empty block with last goes straight to the carry step.
// Reset clears the key registers, the accumulator and the output valid.
// A held-up tag stays in the output register; the next message can be taken
// meanwhile, and its own tag waits in the final step until the slot frees.
module poly1305_mac_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  p1305_pkg::p1305_reg_t   cfg_index,
    input  logic [63:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [63:0]             block_low,
    input  logic [63:0]             block_high,
    input  logic [4:0]              byte_count,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [63:0]             tag_low,
    output logic [63:0]             tag_high
);
    import p1305_pkg::*;

    // Sequencer
    p1305_state_t state_reg, state_next;
    p1305_ctrl_t  ctrl;
    logic [2:0]   col_reg, col_next;
    logic [2:0]   term_reg, term_next;
    logic         last_reg, last_next;
    logic         in_accept;
    logic         tag_go;

    // Key registers
    logic [63:0]  r_low_reg, r_high_reg, s_low_reg, s_high_reg;

    // Datapath
    acc_limb_t    acc_reg [NLIMB];
    acc_limb_t    acc_next [NLIMB];
    hs_limb_t     hsum_reg [NLIMB];
    hs_limb_t     hsum_next [NLIMB];
    r_limb_t      r_limb [NLIMB];
    logic [129:0] padded;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic         prod_vld_reg, prod_vld_next;
    logic         prod_first_reg, prod_last_reg;
    logic [2:0]   prod_col_reg;
    logic [DACC_W-1:0]  dacc_reg, dacc_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [DACC_W-1:0]  col_sum;
    logic [FOLD_W-1:0]  fold0;
    acc_limb_t    fh [NLIMB];
    acc_limb_t    gh [NLIMB];
    logic         ge_p;
    logic [127:0] tag_reg, tag_next;
    logic         out_valid_reg, out_valid_next;

    assign cfg_ready = 1'b1;
    assign in_stall  = ctrl.in_stall;
    assign in_accept = in_valid && !ctrl.in_stall;
    assign tag_go    = ctrl.fin_tag && !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign tag_low   = tag_reg[63:0];
    assign tag_high  = tag_reg[127:64];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_count != 5'd0)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (last)
                    begin
                        state_next = ST_FIN_CARRY;
                    end
                end
            end
            ST_MUL:
            begin
                if (col_reg == 3'(NLIMB - 1) && term_reg == 3'(NLIMB - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:     state_next = ST_FOLD;
            ST_FOLD:      state_next = last_reg ? ST_FIN_CARRY : ST_IDLE;
            ST_FIN_CARRY: state_next = ST_FIN_SUB;
            ST_FIN_SUB:   state_next = ST_FIN_TAG;
            ST_FIN_TAG:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:      ctrl.in_stall = 1'b0;
            ST_MUL:
            begin
                ctrl.in_stall  = 1'b1;
                ctrl.mul_issue = 1'b1;
            end
            ST_DRAIN:     ctrl.in_stall = 1'b1;
            ST_FOLD:
            begin
                ctrl.in_stall = 1'b1;
                ctrl.fold     = 1'b1;
            end
            ST_FIN_CARRY:
            begin
                ctrl.in_stall  = 1'b1;
                ctrl.fin_carry = 1'b1;
            end
            ST_FIN_SUB:
            begin
                ctrl.in_stall = 1'b1;
                ctrl.fin_sub  = 1'b1;
            end
            ST_FIN_TAG:
            begin
                ctrl.in_stall = 1'b1;
                ctrl.fin_tag  = 1'b1;
            end
            default:      ctrl.in_stall = 1'b1;
        endcase
    end

    // Product counters: five terms per column, five columns
    always_comb
    begin
        col_next  = col_reg;
        term_next = term_reg;
        last_next = last_reg;
        if (in_accept)
        begin
            col_next  = 3'd0;
            term_next = 3'd0;
            last_next = last;
        end
        else if (ctrl.mul_issue)
        begin
            if (term_reg == 3'(NLIMB - 1))
            begin
                term_next = 3'd0;
                col_next  = col_reg + 3'd1;
            end
            else
            begin
                term_next = term_reg + 3'd1;
            end
        end
    end

    // Clamp r and split into limbs
    always_comb
    begin
        logic [63:0] rl;
        logic [63:0] rh;
        rl = r_low_reg & CLAMP_LOW;
        rh = r_high_reg & CLAMP_HIGH;
        r_limb[0] = rl[25:0];
        r_limb[1] = rl[51:26];
        r_limb[2] = {rh[13:0], rl[63:52]};
        r_limb[3] = rh[39:14];
        r_limb[4] = {2'b00, rh[63:40]};
    end

    // Pad the block and add it to the accumulator on transfer
    assign padded = pad_block(block_low, block_high, byte_count);

    always_comb
    begin
        for (int i = 0; i < NLIMB; i++)
        begin
            hsum_next[i] = hsum_reg[i];
            if (in_accept)
            begin
                hsum_next[i] = HS_W'(acc_reg[i]) + HS_W'(padded[LIMB_W*i +: LIMB_W]);
            end
        end
    end

    // Shared multiplier: h[term] times r or 5r, wrapped column index
    always_comb
    begin
        logic          wrap;
        logic [2:0]    cidx;
        r_limb_t       cr;
        logic [COEF_W-1:0] coef;
        wrap = term_reg > col_reg;
        cidx = wrap ? (col_reg + 3'(NLIMB) - term_reg) : (col_reg - term_reg);
        cr   = r_limb[cidx];
        coef = wrap ? (COEF_W'({cr, 2'b00}) + COEF_W'(cr)) : COEF_W'(cr);
        prod_next     = PROD_W'(hsum_reg[term_reg]) * PROD_W'(coef);
        prod_vld_next = ctrl.mul_issue;
    end

    // Column accumulate, carry rippled into the next column's start
    always_comb
    begin
        logic [DACC_W-1:0] base;
        if (prod_first_reg)
        begin
            base = (prod_col_reg == 3'd0) ? '0 : DACC_W'(carry_reg);
        end
        else
        begin
            base = dacc_reg;
        end
        col_sum    = base + DACC_W'(prod_reg);
        dacc_next  = dacc_reg;
        carry_next = carry_reg;
        if (prod_vld_reg)
        begin
            dacc_next = col_sum;
            if (prod_last_reg)
            begin
                carry_next = col_sum[DACC_W-1:LIMB_W];
            end
        end
    end

    // Fold the top carry times five into limb 0
    assign fold0 = FOLD_W'(acc_reg[0][LIMB_W-1:0]) + FOLD_W'({carry_reg, 2'b00})
                 + FOLD_W'(carry_reg);

    // Final carry pass over the partially reduced accumulator
    always_comb
    begin
        logic [HS_W-1:0] t;
        logic [1:0]      c;
        t     = HS_W'(acc_reg[1]);
        c     = t[HS_W-1:LIMB_W];
        fh[1] = ACC_W'(t[LIMB_W-1:0]);
        for (int i = 2; i < NLIMB; i++)
        begin
            t     = HS_W'(acc_reg[i]) + HS_W'(c);
            c     = t[HS_W-1:LIMB_W];
            fh[i] = ACC_W'(t[LIMB_W-1:0]);
        end
        t     = HS_W'(acc_reg[0]) + HS_W'({c, 2'b00}) + HS_W'(c);
        c     = t[HS_W-1:LIMB_W];
        fh[0] = ACC_W'(t[LIMB_W-1:0]);
        fh[1] = fh[1] + ACC_W'(c);
    end

    // Trial subtraction of p: h + 5 - 2^130
    always_comb
    begin
        logic [HS_W-1:0] t;
        logic [1:0]      c;
        t     = HS_W'(acc_reg[0]) + HS_W'(5);
        c     = t[HS_W-1:LIMB_W];
        gh[0] = ACC_W'(t[LIMB_W-1:0]);
        for (int i = 1; i < NLIMB; i++)
        begin
            t     = HS_W'(acc_reg[i]) + HS_W'(c);
            c     = t[HS_W-1:LIMB_W];
            gh[i] = ACC_W'(t[LIMB_W-1:0]);
        end
        ge_p = (c != 2'd0);
    end

    // Pack the limbs and add s
    always_comb
    begin
        logic [63:0] pk_lo;
        logic [63:0] pk_hi;
        pk_lo = 64'(acc_reg[0][LIMB_W-1:0]) | (64'(acc_reg[1]) << 26)
              | {acc_reg[2][11:0], 52'b0};
        pk_hi = 64'(acc_reg[2][LIMB_W-1:12]) | (64'(acc_reg[3][LIMB_W-1:0]) << 14)
              | {acc_reg[4][23:0], 40'b0};
        tag_next = tag_reg;
        if (tag_go)
        begin
            tag_next = {pk_hi, pk_lo} + {s_high_reg, s_low_reg};
        end
    end

    // Accumulator update
    always_comb
    begin
        for (int i = 0; i < NLIMB; i++)
        begin
            acc_next[i] = acc_reg[i];
        end
        if (prod_vld_reg && prod_last_reg)
        begin
            acc_next[prod_col_reg] = ACC_W'(col_sum[LIMB_W-1:0]);
        end
        if (ctrl.fold)
        begin
            acc_next[0] = ACC_W'(fold0[LIMB_W-1:0]);
            acc_next[1] = acc_reg[1] + ACC_W'(fold0[FOLD_W-1:LIMB_W]);
        end
        if (ctrl.fin_carry)
        begin
            for (int i = 0; i < NLIMB; i++)
            begin
                acc_next[i] = fh[i];
            end
        end
        if (ctrl.fin_sub && ge_p)
        begin
            for (int i = 0; i < NLIMB; i++)
            begin
                acc_next[i] = gh[i];
            end
        end
        if (tag_go)
        begin
            for (int i = 0; i < NLIMB; i++)
            begin
                acc_next[i] = '0;
            end
        end
    end

    // Output valid: hold while stalled, raise on a new tag
    assign out_valid_next = (out_valid_reg && out_stall) || tag_go;

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= 3'd0;
            term_reg      <= 3'd0;
            last_reg      <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            r_low_reg     <= '0;
            r_high_reg    <= '0;
            s_low_reg     <= '0;
            s_high_reg    <= '0;
            for (int i = 0; i < NLIMB; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            term_reg      <= term_next;
            last_reg      <= last_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NLIMB; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
            // Key register transfer
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_R_LOW:  r_low_reg  <= cfg_data;
                    REG_R_HIGH: r_high_reg <= cfg_data;
                    REG_S_LOW:  s_low_reg  <= cfg_data;
                    REG_S_HIGH: s_high_reg <= cfg_data;
                    default:    r_low_reg  <= r_low_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NLIMB; i++)
        begin
            hsum_reg[i] <= hsum_next[i];
        end
        prod_reg       <= prod_next;
        prod_first_reg <= (term_reg == 3'd0);
        prod_last_reg  <= (term_reg == 3'(NLIMB - 1));
        prod_col_reg   <= col_reg;
        dacc_reg       <= dacc_next;
        carry_reg      <= carry_next;
        tag_reg        <= tag_next;
    end

`ifndef SYNTHESIS
    // A product in flight was issued from the multiply step
    a_prod_from_mul: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> $past(state_reg) == ST_MUL)
        else $error("product valid without a multiply issue");

    // The product pipe is empty when the top carry is folded
    a_drained_at_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> !prod_vld_reg)
        else $error("fold while a product is still in flight");

    // A pending tag holds the final step
    a_tag_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN_TAG && out_valid_reg && out_stall)
        |=> (state_reg == ST_FIN_TAG))
        else $error("tag step left while the output slot was full");

    // Issuing a tag clears the accumulator and raises the output
    a_tag_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN_TAG && !(out_valid_reg && out_stall))
        |=> (out_valid_reg && acc_reg[0] == '0 && acc_reg[1] == '0
             && acc_reg[4] == '0))
        else $error("accumulator not cleared after tag");

    // No input transfer while limb products are in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> in_stall)
        else $error("input taken during multiply");
`endif

endmodule

// ===== verif/poly1305_mac_checker.sv =====
// Tag checker for poly1305_mac_top: follows key writes and block transfers,
// predicts each tag in radix 2^26 limbs and compares every tag transfer.
// Depends on p1305_pkg for the register index type.
module poly1305_mac_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  p1305_pkg::p1305_reg_t  cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [63:0]            block_low,
    input  logic [63:0]            block_high,
    input  logic [4:0]             byte_count,
    input  logic                   last,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [63:0]            tag_low,
    input  logic [63:0]            tag_high,
    output int                     tags_pending,
    output int                     mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import p1305_pkg::*;

    localparam logic [63:0] R_MASK_LO = 64'h0ffffffc_0fffffff;
    localparam logic [63:0] R_MASK_HI = 64'h0ffffffc_0ffffffc;
    localparam logic [63:0] LIMB_MASK = 64'h0000_0000_03ff_ffff;
    localparam logic [31:0] LIMB32    = 32'h03ff_ffff;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } tag_t;

    logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [31:0] acc [5];
    tag_t        tags_due [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: tag check: %s", $time, msg);
        mismatches++;
    endtask

    // Add one padded block to the accumulator and multiply by clamped r, partly reduced
    task automatic absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] hibit);
        logic [63:0] rl, rh, r0, r1, r2, r3, r4, f1, f2, f3, f4;
        logic [63:0] h0, h1, h2, h3, h4, d0, d1, d2, d3, d4, c;
        rl = key_r_lo & R_MASK_LO;
        rh = key_r_hi & R_MASK_HI;
        r0 = rl & LIMB_MASK;
        r1 = (rl >> 26) & LIMB_MASK;
        r2 = ((rl >> 52) | (rh << 12)) & LIMB_MASK;
        r3 = (rh >> 14) & LIMB_MASK;
        r4 = rh >> 40;
        f1 = r1 * 64'd5;
        f2 = r2 * 64'd5;
        f3 = r3 * 64'd5;
        f4 = r4 * 64'd5;

        h0 = 64'(acc[0]) + (lo & LIMB_MASK);
        h1 = 64'(acc[1]) + ((lo >> 26) & LIMB_MASK);
        h2 = 64'(acc[2]) + (((lo >> 52) | (hi << 12)) & LIMB_MASK);
        h3 = 64'(acc[3]) + ((hi >> 14) & LIMB_MASK);
        h4 = 64'(acc[4]) + ((hi >> 40) | (hibit << 24));

        d0 = h0 * r0 + h1 * f4 + h2 * f3 + h3 * f2 + h4 * f1;
        d1 = h0 * r1 + h1 * r0 + h2 * f4 + h3 * f3 + h4 * f2;
        d2 = h0 * r2 + h1 * r1 + h2 * r0 + h3 * f4 + h4 * f3;
        d3 = h0 * r3 + h1 * r2 + h2 * r1 + h3 * r0 + h4 * f4;
        d4 = h0 * r4 + h1 * r3 + h2 * r2 + h3 * r1 + h4 * r0;

        // One carry pass; the top carry folds back into limb 0 times five
        c = d0 >> 26;  h0 = d0 & LIMB_MASK;
        d1 += c;  c = d1 >> 26;  h1 = d1 & LIMB_MASK;
        d2 += c;  c = d2 >> 26;  h2 = d2 & LIMB_MASK;
        d3 += c;  c = d3 >> 26;  h3 = d3 & LIMB_MASK;
        d4 += c;  c = d4 >> 26;  h4 = d4 & LIMB_MASK;
        h0 += c * 64'd5;  c = h0 >> 26;  h0 &= LIMB_MASK;
        h1 += c;

        acc[0] = h0[31:0];
        acc[1] = h1[31:0];
        acc[2] = h2[31:0];
        acc[3] = h3[31:0];
        acc[4] = h4[31:0];
    endtask

    // Fully reduce the accumulator modulo 2^130-5 and add s modulo 2^128
    function automatic tag_t finish_tag();
        logic [31:0] h0, h1, h2, h3, h4, g0, g1, g2, g3, g4, c, keep;
        logic [63:0] lo, hi, sum_lo;
        tag_t        t;
        h0 = acc[0];
        h1 = acc[1];
        h2 = acc[2];
        h3 = acc[3];
        h4 = acc[4];

        c = h1 >> 26;  h1 &= LIMB32;  h2 += c;
        c = h2 >> 26;  h2 &= LIMB32;  h3 += c;
        c = h3 >> 26;  h3 &= LIMB32;  h4 += c;
        c = h4 >> 26;  h4 &= LIMB32;  h0 += c * 32'd5;
        c = h0 >> 26;  h0 &= LIMB32;  h1 += c;

        // Trial subtraction of p; take it when it does not borrow
        g0 = h0 + 32'd5;  c = g0 >> 26;  g0 &= LIMB32;
        g1 = h1 + c;  c = g1 >> 26;  g1 &= LIMB32;
        g2 = h2 + c;  c = g2 >> 26;  g2 &= LIMB32;
        g3 = h3 + c;  c = g3 >> 26;  g3 &= LIMB32;
        g4 = h4 + c - 32'h0400_0000;
        keep = (g4 >> 31) - 32'd1;
        h0 = (h0 & ~keep) | (g0 & keep);
        h1 = (h1 & ~keep) | (g1 & keep);
        h2 = (h2 & ~keep) | (g2 & keep);
        h3 = (h3 & ~keep) | (g3 & keep);
        h4 = (h4 & ~keep) | (g4 & keep & LIMB32);

        lo = 64'(h0) | (64'(h1) << 26) | (64'(h2) << 52);
        hi = (64'(h2) >> 12) | (64'(h3) << 14) | (64'(h4) << 40);
        sum_lo = lo + key_s_lo;
        t.lo = sum_lo;
        t.hi = hi + key_s_hi + ((sum_lo < lo) ? 64'd1 : 64'd0);
        return t;
    endfunction

    // Pad the block by its byte count, absorb it, and queue a tag on last
    task automatic take_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] count, input logic lst);
        logic [4:0]  n;
        int          sh;
        logic [63:0] low_mask;
        n = (count > 5'd16) ? 5'd16 : count;
        if (n == 5'd16)
        begin
            absorb_block(lo, hi, 64'd1);
        end
        else if (n >= 5'd8)
        begin
            sh = (int'(n) - 8) * 8;
            low_mask = (64'd1 << sh) - 64'd1;
            absorb_block(lo, (hi & low_mask) | (64'd1 << sh), 64'd0);
        end
        else if (n != 5'd0)
        begin
            sh = int'(n) * 8;
            low_mask = (64'd1 << sh) - 64'd1;
            absorb_block((lo & low_mask) | (64'd1 << sh), 64'd0, 64'd0);
        end
        if (lst)
        begin
            tags_due.push_back(finish_tag());
            foreach (acc[i])
            begin
                acc[i] = '0;
            end
        end
    endtask

    // Watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        tag_t want;
        if (!rst_n)
        begin
            key_r_lo = '0;
            key_r_hi = '0;
            key_s_lo = '0;
            key_s_hi = '0;
            foreach (acc[i])
            begin
                acc[i] = '0;
            end
            tags_due.delete();
            tags_pending = 0;
            mismatches = 0;
        end
        else
        begin
            // Compare a tag transfer with the oldest tag due
            if (out_valid && !out_stall)
            begin
                if (tags_due.size() == 0)
                begin
                    report_mismatch($sformatf("tag %h_%h with none due", tag_high, tag_low));
                end
                else
                begin
                    want = tags_due.pop_front();
                    if (tag_low !== want.lo)
                    begin
                        report_mismatch($sformatf("tag_low got %h, expected %h",
                                                  tag_low, want.lo));
                    end
                    if (tag_high !== want.hi)
                    begin
                        report_mismatch($sformatf("tag_high got %h, expected %h",
                                                  tag_high, want.hi));
                    end
                end
            end

            // Track key writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_R_LOW:  key_r_lo = cfg_data;
                    REG_R_HIGH: key_r_hi = cfg_data;
                    REG_S_LOW:  key_s_lo = cfg_data;
                    REG_S_HIGH: key_s_hi = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                take_block(block_low, block_high, byte_count, last);
            end
            tags_pending = tags_due.size();
        end
    end

endmodule

// ===== verif/tb_poly1305_mac_top.sv =====
// Testbench top for poly1305_mac_top: clock, reset, key writes, block stimulus
// and random stalls; the tag checker in poly1305_mac_checker gives the verdict.
// Depends on p1305_pkg, poly1305_mac_top and poly1305_mac_checker.
module tb_poly1305_mac_top;
    timeunit 1ns;
    timeprecision 1ps;
    import p1305_pkg::*;

    localparam int SETTLE_CYCLES = 40;    // block plus empty finalize, with margin
    localparam int TOTAL_BLOCKS  = 1720;
    localparam int CALM_FROM     = 1500;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    p1305_reg_t  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  byte_count;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] tag_low;
    logic [63:0] tag_high;
    int          tags_pending;
    int          mismatches;

    bit calm = 1'b0;
    int blocks_sent = 0;

    poly1305_mac_top dut (.*);

    poly1305_mac_checker tag_check (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one block and hold it until the transfer; valid stays high afterwards
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] count, input logic lst);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        block_low  <= lo;
        block_high <= hi;
        byte_count <= count;
        last       <= lst;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
        if (count != 5'd0 || lst)
        begin
            blocks_sent++;
        end
    endtask

    // Drop valid, wait for every tag due, then let a pending block finish
    task automatic settle();
        in_valid <= 1'b0;
        while (tags_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input p1305_reg_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh);
        write_reg(REG_R_LOW, rl);
        write_reg(REG_R_HIGH, rh);
        write_reg(REG_S_LOW, sl);
        write_reg(REG_S_HIGH, sh);
    endtask

    // Hold the tag side off in random bursts until the calm part of the run
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #15ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int          nblk;
        logic [4:0]  count;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_R_LOW;
        cfg_data   = '0;
        in_valid   = 1'b0;
        block_low  = '0;
        block_high = '0;
        byte_count = '0;
        last       = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Key still at its reset value of zero
        send_block(rand_word(), rand_word(), 5'd16, 1'b1);
        settle();

        // All-ones key: full, short, empty and oversized counts in one message
        load_key('1, '1, '1, '1);
        send_block('1, '1, 5'd16, 1'b0);
        send_block('0, '0, 5'd16, 1'b0);
        send_block('1, '1, 5'd1, 1'b0);
        send_block('1, '1, 5'd7, 1'b0);
        send_block('1, '1, 5'd8, 1'b0);
        send_block('1, '1, 5'd9, 1'b0);
        send_block(rand_word(), rand_word(), 5'd15, 1'b0);
        send_block('1, '1, 5'd0, 1'b0);
        send_block('1, '1, 5'd20, 1'b0);
        send_block(rand_word(), rand_word(), 5'd31, 1'b0);
        send_block(rand_word(), '1, 5'd15, 1'b1);

        // Empty message, then a message of one short block
        send_block('1, '1, 5'd0, 1'b1);
        send_block(rand_word(), rand_word(), 5'd5, 1'b1);
        settle();

        // With r = 1 two full blocks sum to p, then p - 1: final subtraction boundary
        load_key(64'd1, '0, '0, '0);
        send_block('1, '1, 5'd16, 1'b0);
        send_block(64'hffff_ffff_ffff_fffc, '1, 5'd16, 1'b1);
        send_block('1, '1, 5'd16, 1'b0);
        send_block(64'hffff_ffff_ffff_fffb, '1, 5'd16, 1'b1);
        settle();

        // p + 3 with all-ones s: carry out of the s addition wraps
        write_reg(REG_S_LOW, '1);
        write_reg(REG_S_HIGH, '1);
        send_block('1, '1, 5'd16, 1'b0);
        send_block('1, '1, 5'd16, 1'b1);

        // New key in mid-message applies from the next block
        send_block(rand_word(), rand_word(), 5'd16, 1'b0);
        settle();
        load_key(rand_word(), rand_word(), rand_word(), rand_word());
        send_block(rand_word(), rand_word(), 5'd16, 1'b1);

        // Random messages, now and then under a fresh key
        while (blocks_sent < TOTAL_BLOCKS)
        begin
            if (blocks_sent >= CALM_FROM)
            begin
                calm = 1'b1;
            end
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                settle();
                if ($urandom_range(0, 1) == 0)
                begin
                    load_key(rand_word(), rand_word(), rand_word(), rand_word());
                end
                else
                begin
                    write_reg(p1305_reg_t'($urandom_range(0, 3)), rand_word());
                end
            end
            nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
            for (int i = 0; i < nblk - 1; i++)
            begin
                count = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
                send_block(rand_word(), rand_word(), count, 1'b0);
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: count = 5'd16;
                17, 18:                       count = 5'd0;
                19:                           count = 5'($urandom_range(17, 31));
                default:                      count = 5'($urandom_range(1, 15));
            endcase
            send_block(rand_word(), rand_word(), count, 1'b1);
        end

        settle();
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
